// ----- rtl/steq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table equal-range search: shared definitions
// Types and constants used by the cells, the search controller and the
// port checker.
// ----------------------------------------------------------------------------
package steq_pkg;

  localparam int unsigned MATCH_INDEX_BITS = 6;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_LEFT   = 4'b0100,
    ST_RIGHT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic shift;
    logic compare;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_table_equal_range_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table equal-range search
// Appends keys to a table and answers equal-range queries by binary search.
// ----------------------------------------------------------------------------
// A load transaction appends its key without leaving the idle state; a load
// into a full table is dropped. Each stored key lives in a cell of a shift
// chain, and a load moves every key one cell down the chain. A query compares
// its key against all cells in the accept cycle, then steps through the binary
// search probes, at most ceil(log2(n + 1)) probes for n entries. A hit registers
// its first match in the probe cycle that finds it and then one further match
// per cycle while the result side does not stall. A miss registers its result
// after the last probe, once the search range is empty. A stalled result side
// holds back each result, but not the probes that miss. No new transaction is
// accepted until the last result of a query is registered.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic [63:0]                          key_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [steq_pkg::MATCH_INDEX_BITS-1:0]     match_index_o,
  output logic                                      found_o,
  output logic                                      last_o
);
  import steq_pkg::*;

  cell_ctrl_t             cell_ctrl;
  logic [KEY_BITS-1:0]    key_in;
  logic [KEY_BITS-1:0]    chain [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] gt_vec;

  assign key_in = key_i[KEY_BITS-1:0];

  for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
    logic [KEY_BITS-1:0] prev;
    if (c == 0) begin : g_head
      assign prev = key_in;
    end else begin : g_body
      assign prev = chain[c-1];
    end
    steq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .key_prev_i  (prev),
      .key_query_i (key_in),
      .key_o       (chain[c]),
      .eq_o        (eq_vec[c]),
      .gt_o        (gt_vec[c])
    );
  end

  steq_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .in_stall_o    (in_stall_o),
    .eq_i          (eq_vec),
    .gt_i          (gt_vec),
    .cell_ctrl_o   (cell_ctrl),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_index_o (match_index_o),
    .found_o       (found_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ----- rtl/steq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Table cell
// Holds one stored key, takes its neighbor's key on a load and registers the
// equal and greater-than compare against the query key.
// ----------------------------------------------------------------------------
module steq_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic                  clk_i,
  input  wire steq_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [KEY_BITS-1:0]   key_prev_i,
  input  wire logic [KEY_BITS-1:0]   key_query_i,
  output logic      [KEY_BITS-1:0]   key_o,
  output logic                       eq_o,
  output logic                       gt_o
);
  import steq_pkg::*;

  logic [KEY_BITS-1:0] key_q;
  logic                eq_q;
  logic                gt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q <= key_prev_i;
    end
    if (ctrl_i.compare) begin
      eq_q <= (key_q == key_query_i);
      gt_q <= (key_q > key_query_i);
    end
  end

  assign key_o = key_q;
  assign eq_o  = eq_q;
  assign gt_o  = gt_q;

endmodule
`default_nettype wire

// ----- rtl/steq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Search controller
// Counts stored entries, steps the binary search over the registered compare
// bits of the cells, walks the matching neighbors and drives the result
// register.
// ----------------------------------------------------------------------------
module steq_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic                                   op_i,
  output logic                                        in_stall_o,
  input  wire logic [TABLE_DEPTH-1:0]                 eq_i,
  input  wire logic [TABLE_DEPTH-1:0]                 gt_i,
  output steq_pkg::cell_ctrl_t                        cell_ctrl_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [steq_pkg::MATCH_INDEX_BITS-1:0]       match_index_o,
  output logic                                        found_o,
  output logic                                        last_o
);
  import steq_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] mid_q, mid_d;
  logic          out_valid_q, out_valid_d;
  logic [IW-1:0] idx_q;
  logic          found_q;
  logic          last_q;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] mid_sum;
  logic [IW-1:0] mid_w;
  logic [IW-1:0] mid_cell;
  logic [IW-1:0] left_base;
  logic [IW-1:0] right_base;
  logic [IW-1:0] left_cell;
  logic [IW-1:0] right_cell;
  logic          left_ok;
  logic          right_ok;
  logic          emit;
  logic [IW-1:0] emit_idx;
  logic          emit_found;
  logic          emit_last;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign mid_sum  = lo_q + ((hi_q - CW'(1) - lo_q) >> 1);
  assign mid_w    = mid_sum[IW-1:0];
  assign mid_cell = IW'(count_q - CW'(1) - CW'(mid_w));

  always_comb begin
    case (state_q)
      ST_LEFT: begin
        left_base  = ptr_q;
        right_base = mid_q;
      end
      ST_RIGHT: begin
        left_base  = ptr_q;
        right_base = ptr_q;
      end
      default: begin
        left_base  = mid_w;
        right_base = mid_w;
      end
    endcase
  end

  assign left_cell  = IW'(count_q - CW'(left_base));
  assign right_cell = IW'(count_q - CW'(2) - CW'(right_base));
  assign left_ok    = (left_base != '0) && eq_i[left_cell];
  assign right_ok   = ((CW'(right_base) + CW'(1)) < count_q) && eq_i[right_cell];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    mid_d       = mid_q;
    emit        = 1'b0;
    emit_idx    = ptr_q;
    emit_found  = 1'b1;
    emit_last   = 1'b0;
    cell_ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            if (count_q < CW'(TABLE_DEPTH)) begin
              count_d           = count_q + CW'(1);
              cell_ctrl_o.shift = 1'b1;
            end
          end else begin
            cell_ctrl_o.compare = 1'b1;
            lo_d                = '0;
            hi_d                = count_q;
            state_d             = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          if (eq_i[mid_cell]) begin
            if (out_free) begin
              emit      = 1'b1;
              emit_idx  = mid_w;
              emit_last = !left_ok && !right_ok;
              mid_d     = mid_w;
              if (left_ok) begin
                ptr_d   = mid_w - IW'(1);
                state_d = ST_LEFT;
              end else if (right_ok) begin
                ptr_d   = mid_w + IW'(1);
                state_d = ST_RIGHT;
              end else begin
                state_d = ST_IDLE;
              end
            end
          end else if (gt_i[mid_cell]) begin
            hi_d = CW'(mid_w);
          end else begin
            lo_d = CW'(mid_w) + CW'(1);
          end
        end else if (out_free) begin
          emit       = 1'b1;
          emit_idx   = '0;
          emit_found = 1'b0;
          emit_last  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_LEFT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = !left_ok && !right_ok;
          if (left_ok) begin
            ptr_d = ptr_q - IW'(1);
          end else if (right_ok) begin
            ptr_d   = mid_q + IW'(1);
            state_d = ST_RIGHT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RIGHT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = !right_ok;
          if (right_ok) begin
            ptr_d = ptr_q + IW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ptr_q <= ptr_d;
    mid_q <= mid_d;
    if (emit) begin
      idx_q   <= emit_idx;
      found_q <= emit_found;
      last_q  <= emit_last;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign match_index_o = MATCH_INDEX_BITS'(idx_q);
  assign found_o       = found_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ----- rtl/steq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the search block for result and busy consistency.
// ----------------------------------------------------------------------------
module steq_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic [63:0]                          key_i,
  input  wire logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  input  wire logic [steq_pkg::MATCH_INDEX_BITS-1:0] match_index_o,
  input  wire logic                                 found_o,
  input  wire logic                                 last_o
);
  import steq_pkg::*;

  logic unused_key;
  assign unused_key = ^key_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_index_o)
      && $stable(found_o) && $stable(last_o))
    else $error("Stalled result transaction changed.");

  a_miss_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && (match_index_o == '0))
    else $error("Miss result is not a lone final result at index zero.");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_QUERY) |=> in_stall_o)
    else $error("Input not stalled after a query was accepted.");

  a_open_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("Input accepted while a query still has results to give.");

endmodule

bind sorted_table_equal_range_search steq_checker u_steq_checker (.*);
`default_nettype wire

// ----- tb/sv/sorted_table_equal_range_search_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted table equal-range search testbench
// Loads keys into the table and queries them. A scoreboard class keeps its own
// copy of the table, repeats the binary search with the left and right walks
// for each accepted query, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_tb;
  import steq_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS = 64;
  localparam int RANDOM_ITEMS = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [MATCH_INDEX_BITS-1:0] match_index;
    logic                        found;
    logic                        last;
  } match_result_t;

  class equal_range_scoreboard;
    logic [63:0]   stored_keys[TABLE_DEPTH];
    int            stored_count;
    match_result_t pending_matches[$];
    int            mismatches;

    function new();
      stored_count = 0;
      mismatches = 0;
    endfunction

    function void add_match(int idx, logic hit);
      match_result_t r;
      r.match_index = MATCH_INDEX_BITS'(idx);
      r.found = hit;
      r.last = 1'b0;
      pending_matches.push_back(r);
    endfunction

    function void note_transaction(op_e op, logic [63:0] key);
      int lo;
      int hi;
      int mid;
      int j;
      bit hit;
      if (op == OP_LOAD) begin
        if (stored_count < TABLE_DEPTH) begin
          stored_keys[stored_count] = key;
          stored_count++;
        end
        return;
      end
      hit = 1'b0;
      lo = 0;
      hi = stored_count - 1;
      while (lo <= hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (stored_keys[mid] == key) begin
          hit = 1'b1;
          add_match(mid, 1'b1);
          for (j = mid - 1; j >= 0 && stored_keys[j] == key; j--) add_match(j, 1'b1);
          for (j = mid + 1; j < stored_count && stored_keys[j] == key; j++) begin
            add_match(j, 1'b1);
          end
        end else if (stored_keys[mid] > key) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      if (!hit) add_match(0, 1'b0);
      pending_matches[pending_matches.size() - 1].last = 1'b1;
    endfunction

    function void check_match(logic [MATCH_INDEX_BITS-1:0] match_index, logic found,
                              logic last);
      match_result_t exp;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual index %0d",
                 $time, match_index);
        mismatches++;
        return;
      end
      exp = pending_matches.pop_front();
      if (match_index !== exp.match_index) begin
        $display("%0t: match_index expected %0d actual %0d", $time, exp.match_index,
                 match_index);
        mismatches++;
      end
      if (found !== exp.found) begin
        $display("%0t: found expected %0b actual %0b", $time, exp.found, found);
        mismatches++;
      end
      if (last !== exp.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        op_i;
  logic [63:0]                 key_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [MATCH_INDEX_BITS-1:0] match_index_o;
  logic                        found_o;
  logic                        last_o;

  bit                    no_idle = 1'b0;
  int                    idle_cycles = 0;
  logic [63:0]           top_key;
  equal_range_scoreboard sb = new();

  sorted_table_equal_range_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_index_o(match_index_o),
    .found_o      (found_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] any_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input op_e op, input logic [63:0] key);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(op, key);
    @(negedge clk_i);
  endtask

  task automatic load_next_key();
    if ($urandom_range(19) == 0) begin
      send_item(OP_LOAD, any_key());
    end else begin
      if ($urandom_range(2) != 0) top_key = top_key + ({$urandom(), $urandom()} >> 8) + 1;
      send_item(OP_LOAD, top_key);
    end
  endtask

  task automatic query_random_key();
    int sel;
    logic [63:0] key;
    sel = $urandom_range(99);
    if (sb.stored_count > 0 && sel < 60) begin
      key = sb.stored_keys[$urandom_range(sb.stored_count - 1)];
    end else if (sb.stored_count > 0 && sel < 80) begin
      key = sb.stored_keys[$urandom_range(sb.stored_count - 1)];
      key = $urandom_range(1) ? key + 1 : key - 1;
    end else begin
      key = any_key();
    end
    send_item(OP_QUERY, key);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 34);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_match(match_index_o, found_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] anna_key;
    logic [63:0] bruno_key;
    logic [63:0] alice_key;
    int n;
    int roll;
    bit load;
    anna_key = 64'h616E_6E61_0000_0000;
    bruno_key = 64'h6272_756E_6F00_0000;
    alice_key = 64'h616C_6963_6500_0000;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_LOAD;
    key_i = '0;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(OP_QUERY, 64'h0);
    send_item(OP_QUERY, '1);
    send_item(OP_LOAD, 64'h0);
    send_item(OP_QUERY, 64'h0);
    send_item(OP_QUERY, 64'h1);
    send_item(OP_LOAD, anna_key);
    send_item(OP_LOAD, anna_key);
    send_item(OP_LOAD, anna_key);
    send_item(OP_LOAD, bruno_key);
    send_item(OP_LOAD, bruno_key);
    send_item(OP_QUERY, anna_key);
    send_item(OP_QUERY, bruno_key);
    send_item(OP_QUERY, anna_key + 1);
    send_item(OP_LOAD, alice_key);
    send_item(OP_QUERY, alice_key);
    send_item(OP_QUERY, bruno_key);
    send_item(OP_QUERY, 64'h0);
    send_item(OP_QUERY, '1);
    top_key = bruno_key;

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 120 && n < 180);
      roll = $urandom_range(99);
      load = (sb.stored_count < TABLE_DEPTH) ? (roll < 40) : (roll < 5);
      if (load) begin
        load_next_key();
      end else begin
        query_random_key();
      end
    end
    no_idle = 1'b0;

    while (sb.stored_count < TABLE_DEPTH) load_next_key();
    send_item(OP_LOAD, top_key + 1);
    send_item(OP_LOAD, 64'h0);
    send_item(OP_QUERY, top_key + 1);
    send_item(OP_QUERY, sb.stored_keys[TABLE_DEPTH - 1]);
    send_item(OP_QUERY, sb.stored_keys[0]);
    in_valid_i <= 1'b0;

    while (sb.pending_matches.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_matches.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/steq_pkg.sv
rtl/steq_cell.sv
rtl/steq_ctrl.sv
rtl/sorted_table_equal_range_search.sv
rtl/steq_checker.sv
tb/sv/sorted_table_equal_range_search_tb.sv
